### src/vptw_pkg.sv
// vptw_pkg: widths, register reset values, csr codes and shared types of the
// vertex projection pipeline; no dependencies
`default_nettype none

package vptw_pkg;

   // matrix entry format, signed with FRAC fractional bits
   localparam int ELEM_BITS = 16;
   localparam int FRAC      = 12;

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int VIEW_W     = 32;
   localparam int SIZE_W     = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MV_COL0   = 3'd0,
      CSR_MV_COL1   = 3'd1,
      CSR_MV_COL2   = 3'd2,
      CSR_MV_COL3   = 3'd3,
      CSR_PROJ_A    = 3'd4,
      CSR_PROJ_B    = 3'd5,
      CSR_VIEW_SIZE = 3'd6
   } csr_index_type;

   // reset: identity modelview, unit x/y projection, 640 x 480 window
   localparam logic [CSR_DATA_W-1:0] MV_COL0_RST = 64'd4096;
   localparam logic [CSR_DATA_W-1:0] MV_COL1_RST = 64'd268435456;
   localparam logic [CSR_DATA_W-1:0] MV_COL2_RST = 64'd17592186044416;
   localparam logic [CSR_DATA_W-1:0] MV_COL3_RST = 64'd1152921504606846976;
   localparam logic [CSR_DATA_W-1:0] PROJ_A_RST  = 64'd1152921504606851072;
   localparam logic [CSR_DATA_W-1:0] PROJ_B_RST  = 64'd0;
   localparam logic [VIEW_W-1:0]     VIEW_RST    = 32'd31457920;

   // datapath widths
   localparam int OBJ_W       = 16;
   localparam int MV_PROD_W   = ELEM_BITS + OBJ_W;
   localparam int EYE_SUM_W   = ELEM_BITS + OBJ_W + 2;
   localparam int EYE_W       = 30;
   localparam int CLIP_PROD_W = ELEM_BITS + EYE_W;
   localparam int CLIP_SUM_W  = ELEM_BITS + EYE_W + 2;
   localparam int CLIP_W      = 47;
   localparam int W_W         = EYE_W + 1;
   localparam int WMAG_W      = EYE_W;
   localparam int NUM_W       = 48;
   localparam int HALF_W      = NUM_W / 2;
   localparam int HI_W        = HALF_W + SIZE_W + 1;
   localparam int LO_W        = HALF_W + SIZE_W;
   localparam int PROD_W      = 64;
   localparam int NMAG_W      = PROD_W - 1;
   localparam int DEN_SHIFT   = 5;
   localparam int DEN_W       = WMAG_W + DEN_SHIFT;
   localparam int WIN_W       = 24;
   localparam int DIV_STEPS   = WIN_W;
   localparam int REM_W       = DEN_W + DIV_STEPS - 1;

   // pipeline depth
   localparam int FRONT_STAGES = 8;
   localparam int BACK_STAGES  = DIV_STEPS + 2;
   localparam int NST          = FRONT_STAGES + BACK_STAGES;

   localparam logic signed [63:0] EYE_MAX  = (64'sd1 <<< (EYE_W - 1)) - 64'sd1;
   localparam logic signed [63:0] EYE_MIN  = -(64'sd1 <<< (EYE_W - 1));
   localparam logic signed [63:0] CLIP_MAX = (64'sd1 <<< (CLIP_W - 1)) - 64'sd1;
   localparam logic signed [63:0] CLIP_MIN = -(64'sd1 <<< (CLIP_W - 1));

   // divider input: magnitudes and quotient signs of both lanes
   typedef struct packed {
      logic [NMAG_W-1:0] mag_x;
      logic              neg_x;
      logic [NMAG_W-1:0] mag_y;
      logic              neg_y;
      logic [DEN_W-1:0]  den;
      logic              w_zero;
   } div_in_type;

   typedef struct packed {
      logic signed [WIN_W-1:0] win_x;
      logic signed [WIN_W-1:0] win_y;
      logic                    w_zero;
   } win_type;

   // entry k of a packed register; fields past bit 63 read as zero
   function automatic logic signed [ELEM_BITS-1:0] elem(logic [CSR_DATA_W-1:0] word, int k);
      logic [2*CSR_DATA_W-1:0] wide;
      wide = {{CSR_DATA_W{1'b0}}, word} >> (k * ELEM_BITS);
      return wide[ELEM_BITS-1:0];
   endfunction

   function automatic logic signed [EYE_W-1:0] sat_eye(logic signed [EYE_SUM_W-1:0] v);
      logic signed [EYE_W-1:0] r;
      if (v > EYE_MAX) begin
         r = EYE_MAX[EYE_W-1:0];
      end else if (v < EYE_MIN) begin
         r = EYE_MIN[EYE_W-1:0];
      end else begin
         r = EYE_W'(v);
      end
      return r;
   endfunction

   function automatic logic signed [CLIP_W-1:0] sat_clip(logic signed [CLIP_SUM_W-1:0] v);
      logic signed [CLIP_W-1:0] r;
      if (v > CLIP_MAX) begin
         r = CLIP_MAX[CLIP_W-1:0];
      end else if (v < CLIP_MIN) begin
         r = CLIP_MIN[CLIP_W-1:0];
      end else begin
         r = CLIP_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### src/vptw_divide.sv
// vptw_divide: restoring divider pipeline, one quotient bit per stage, for the
// x and y lanes plus the final sign and saturation; uses vptw_pkg
`default_nettype none

module vptw_divide (
   input  logic                                 clock,
   input  logic [vptw_pkg::BACK_STAGES-1:0]     en,
   input  vptw_pkg::div_in_type                 div_in,
   output vptw_pkg::win_type                    win
);
   import vptw_pkg::*;

   localparam logic signed [WIN_W-1:0] WIN_MAX = {1'b0, {(WIN_W-1){1'b1}}};
   localparam logic signed [WIN_W-1:0] WIN_MIN = {1'b1, {(WIN_W-1){1'b0}}};

   logic [REM_W-1:0] rem_x_ff [DIV_STEPS];
   logic [REM_W-1:0] rem_y_ff [DIV_STEPS];
   logic [DEN_W-1:0] den_ff   [DIV_STEPS];
   logic [WIN_W-1:0] q_x_ff   [DIV_STEPS+1];
   logic [WIN_W-1:0] q_y_ff   [DIV_STEPS+1];
   logic             ovf_x_ff [DIV_STEPS+1];
   logic             ovf_y_ff [DIV_STEPS+1];
   logic             neg_x_ff [DIV_STEPS+1];
   logic             neg_y_ff [DIV_STEPS+1];
   logic             wz_ff    [DIV_STEPS+1];

   logic             ovf_x_in, ovf_y_in;
   logic [REM_W-1:0] dsh      [DIV_STEPS];
   logic             take_x   [DIV_STEPS];
   logic             take_y   [DIV_STEPS];
   logic [WIN_W-1:0] q_x_in   [DIV_STEPS];
   logic [WIN_W-1:0] q_y_in   [DIV_STEPS];
   logic [REM_W-1:0] rem_x_in [DIV_STEPS-1];
   logic [REM_W-1:0] rem_y_in [DIV_STEPS-1];
   win_type          win_in, win_ff;

   function automatic logic signed [WIN_W-1:0] sat_win(logic [WIN_W-1:0] q, logic ovf,
                                                        logic neg);
      logic signed [WIN_W-1:0] r;
      if (!neg) begin
         r = (ovf || q[WIN_W-1]) ? WIN_MAX : $signed(q);
      end else if (ovf || (q[WIN_W-1] && (q[WIN_W-2:0] != '0))) begin
         r = WIN_MIN;
      end else begin
         r = $signed(-q);
      end
      return r;
   endfunction

   // quotient would not fit the window range
   assign ovf_x_in = div_in.mag_x >= (NMAG_W'(div_in.den) << DIV_STEPS);
   assign ovf_y_in = div_in.mag_y >= (NMAG_W'(div_in.den) << DIV_STEPS);

   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         dsh[k]    = REM_W'(den_ff[k]) << (DIV_STEPS - 1 - k);
         take_x[k] = rem_x_ff[k] >= dsh[k];
         take_y[k] = rem_y_ff[k] >= dsh[k];
         q_x_in[k] = q_x_ff[k] | (WIN_W'(take_x[k]) << (DIV_STEPS - 1 - k));
         q_y_in[k] = q_y_ff[k] | (WIN_W'(take_y[k]) << (DIV_STEPS - 1 - k));
      end
      for (int k = 0; k < DIV_STEPS - 1; k++) begin
         rem_x_in[k] = take_x[k] ? rem_x_ff[k] - dsh[k] : rem_x_ff[k];
         rem_y_in[k] = take_y[k] ? rem_y_ff[k] - dsh[k] : rem_y_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_x_ff[0] <= REM_W'(div_in.mag_x);
         rem_y_ff[0] <= REM_W'(div_in.mag_y);
         den_ff[0]   <= div_in.den;
         q_x_ff[0]   <= '0;
         q_y_ff[0]   <= '0;
         ovf_x_ff[0] <= ovf_x_in;
         ovf_y_ff[0] <= ovf_y_in;
         neg_x_ff[0] <= div_in.neg_x;
         neg_y_ff[0] <= div_in.neg_y;
         wz_ff[0]    <= div_in.w_zero;
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (en[k+1]) begin
            q_x_ff[k+1]   <= q_x_in[k];
            q_y_ff[k+1]   <= q_y_in[k];
            ovf_x_ff[k+1] <= ovf_x_ff[k];
            ovf_y_ff[k+1] <= ovf_y_ff[k];
            neg_x_ff[k+1] <= neg_x_ff[k];
            neg_y_ff[k+1] <= neg_y_ff[k];
            wz_ff[k+1]    <= wz_ff[k];
         end
      end
      for (int k = 0; k < DIV_STEPS - 1; k++) begin
         if (en[k+1]) begin
            rem_x_ff[k+1] <= rem_x_in[k];
            rem_y_ff[k+1] <= rem_y_in[k];
            den_ff[k+1]   <= den_ff[k];
         end
      end
   end

   // zero divisor forces zero coordinates
   always_comb begin
      if (wz_ff[DIV_STEPS]) begin
         win_in.win_x  = '0;
         win_in.win_y  = '0;
         win_in.w_zero = 1'b1;
      end else begin
         win_in.win_x  = sat_win(q_x_ff[DIV_STEPS], ovf_x_ff[DIV_STEPS], neg_x_ff[DIV_STEPS]);
         win_in.win_y  = sat_win(q_y_ff[DIV_STEPS], ovf_y_ff[DIV_STEPS], neg_y_ff[DIV_STEPS]);
         win_in.w_zero = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[BACK_STAGES-1]) begin
         win_ff <= win_in;
      end
   end

   assign win = win_ff;

endmodule

`default_nettype wire

### src/vertex_project_to_window.sv
// vertex_project_to_window: top level of the vertex projection pipeline
// depends on vptw_pkg and vptw_divide
//
// usage
// - request channel (req_*): one object point per request, x/y/z in signed
//   q4.12; a request is taken on a clock edge with req_valid high and
//   req_stall low
// - response channel (rsp_*): window x/y in pixels with 8 fractional bits,
//   saturated, and w_zero when the eye z is zero (coordinates then zero);
//   taken on an edge with rsp_valid high and rsp_stall low
// - csr channel: csr_index selects modelview columns 0..3, projection words
//   a and b, and the view size; csr_ready is always high, index 7 is ignored;
//   write only while no request is in flight
// - throughput: one request per clock while req_stall is low; between
//   acceptance and rsp_valid lie 8 transform/scale stages, 1 range check,
//   24 divider stages and 1 output stage; the 24-stage quotient chain sets the depth
// - stall: a stage holds only while it and every stage ahead are full and
//   rsp_stall is high, so empty slots keep filling and req_stall rises only
//   when every stage holds a request and rsp_stall is high
// - reset: clears all stage valid bits and loads identity modelview, unit
//   x/y projection and a 640 x 480 window
`default_nettype none

module vertex_project_to_window (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [vptw_pkg::OBJ_W-1:0]      req_obj_x,
   input  logic signed [vptw_pkg::OBJ_W-1:0]      req_obj_y,
   input  logic signed [vptw_pkg::OBJ_W-1:0]      req_obj_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [vptw_pkg::WIN_W-1:0]      rsp_win_x,
   output logic signed [vptw_pkg::WIN_W-1:0]      rsp_win_y,
   output logic                                   rsp_w_zero,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [vptw_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [vptw_pkg::CSR_DATA_W-1:0]        csr_data
);
   import vptw_pkg::*;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] mv_ff [4];
   logic [CSR_DATA_W-1:0] mv_in [4];
   logic [CSR_DATA_W-1:0] proj_a_ff, proj_a_in;
   logic [CSR_DATA_W-1:0] proj_b_ff, proj_b_in;
   logic [VIEW_W-1:0]     view_ff, view_in;

   assign csr_ready = 1'b1;

   always_comb begin
      mv_in     = mv_ff;
      proj_a_in = proj_a_ff;
      proj_b_in = proj_b_ff;
      view_in   = view_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MV_COL0:   mv_in[0] = csr_data;
            CSR_MV_COL1:   mv_in[1] = csr_data;
            CSR_MV_COL2:   mv_in[2] = csr_data;
            CSR_MV_COL3:   mv_in[3] = csr_data;
            CSR_PROJ_A:    proj_a_in = csr_data;
            CSR_PROJ_B:    proj_b_in = csr_data;
            CSR_VIEW_SIZE: view_in = csr_data[VIEW_W-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff[0]  <= MV_COL0_RST;
         mv_ff[1]  <= MV_COL1_RST;
         mv_ff[2]  <= MV_COL2_RST;
         mv_ff[3]  <= MV_COL3_RST;
         proj_a_ff <= PROJ_A_RST;
         proj_b_ff <= PROJ_B_RST;
         view_ff   <= VIEW_RST;
      end else begin
         mv_ff     <= mv_in;
         proj_a_ff <= proj_a_in;
         proj_b_ff <= proj_b_in;
         view_ff   <= view_in;
      end
   end

   // unpacked matrix entries; m_elem is column major, px/py are the x and y
   // projection rows in eye x, y, z, w order
   logic signed [ELEM_BITS-1:0] m_elem [16];
   logic signed [ELEM_BITS-1:0] px [4];
   logic signed [ELEM_BITS-1:0] py [4];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int e = 0; e < 4; e++) begin
            m_elem[4*c+e] = elem(mv_ff[c], e);
         end
      end
      px[0] = elem(proj_a_ff, 0);
      px[1] = elem(proj_a_ff, 2);
      px[2] = elem(proj_b_ff, 0);
      px[3] = elem(proj_b_ff, 2);
      py[0] = elem(proj_a_ff, 1);
      py[1] = elem(proj_a_ff, 3);
      py[2] = elem(proj_b_ff, 1);
      py[3] = elem(proj_b_ff, 3);
   end

   // ------------------------------------------------------------------
   // stage valid bits and enables
   // a stage loads when rsp_stall is low, or when it or any stage ahead of it is empty
   // ------------------------------------------------------------------
   logic [NST-1:0] v_ff, v_in, en, v_shift;

   always_comb begin
      for (int i = 0; i < NST; i++) begin
         en[i] = !rsp_stall || ((~v_ff & ~((NST'(1) << i) - NST'(1))) != '0);
      end
   end

   assign v_shift = {v_ff[NST-2:0], req_valid};
   assign v_in    = (en & v_shift) | (~en & v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = v_ff[NST-1];

   // ------------------------------------------------------------------
   // stage 0: modelview products
   // ------------------------------------------------------------------
   logic signed [OBJ_W-1:0]     obj [3];
   logic signed [MV_PROD_W-1:0] s0_prod_in [4][3];
   logic signed [MV_PROD_W-1:0] s0_prod_ff [4][3];

   assign obj[0] = req_obj_x;
   assign obj[1] = req_obj_y;
   assign obj[2] = req_obj_z;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            s0_prod_in[r][c] = MV_PROD_W'(m_elem[4*c+r] * obj[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_prod_ff <= s0_prod_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: eye coordinates, floored to q.12 and saturated
   // ------------------------------------------------------------------
   logic signed [EYE_SUM_W-1:0] eye_sum [4];
   logic signed [EYE_SUM_W-1:0] eye_fl  [4];
   logic signed [EYE_W-1:0]     s1_eye_in [4];
   logic signed [EYE_W-1:0]     s1_eye_ff [4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         // translation column enters at unit object w
         eye_sum[r] = EYE_SUM_W'(s0_prod_ff[r][0]) + EYE_SUM_W'(s0_prod_ff[r][1])
                    + EYE_SUM_W'(s0_prod_ff[r][2]) + (EYE_SUM_W'(m_elem[12+r]) <<< FRAC);
         eye_fl[r]    = eye_sum[r] >>> FRAC;
         s1_eye_in[r] = sat_eye(eye_fl[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_eye_ff <= s1_eye_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: projection products, w = -eye z
   // ------------------------------------------------------------------
   logic signed [CLIP_PROD_W-1:0] s2_cx_in [4], s2_cx_ff [4];
   logic signed [CLIP_PROD_W-1:0] s2_cy_in [4], s2_cy_ff [4];
   logic signed [W_W-1:0]         s2_w_in, s2_w_ff;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         s2_cx_in[j] = CLIP_PROD_W'(px[j] * s1_eye_ff[j]);
         s2_cy_in[j] = CLIP_PROD_W'(py[j] * s1_eye_ff[j]);
      end
      s2_w_in = -W_W'(s1_eye_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_cx_ff <= s2_cx_in;
         s2_cy_ff <= s2_cy_in;
         s2_w_ff  <= s2_w_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: clip x/y sums, saturated
   // ------------------------------------------------------------------
   logic signed [CLIP_SUM_W-1:0] clip_sum_x, clip_sum_y;
   logic signed [CLIP_W-1:0]     s3_clip_x_in, s3_clip_x_ff;
   logic signed [CLIP_W-1:0]     s3_clip_y_in, s3_clip_y_ff;
   logic signed [W_W-1:0]        s3_w_ff;
   logic                         s3_wz_in, s3_wz_ff;

   always_comb begin
      clip_sum_x = CLIP_SUM_W'(s2_cx_ff[0]) + CLIP_SUM_W'(s2_cx_ff[1])
                 + CLIP_SUM_W'(s2_cx_ff[2]) + CLIP_SUM_W'(s2_cx_ff[3]);
      clip_sum_y = CLIP_SUM_W'(s2_cy_ff[0]) + CLIP_SUM_W'(s2_cy_ff[1])
                 + CLIP_SUM_W'(s2_cy_ff[2]) + CLIP_SUM_W'(s2_cy_ff[3]);
      s3_clip_x_in = sat_clip(clip_sum_x);
      s3_clip_y_in = sat_clip(clip_sum_y);
      s3_wz_in     = (s2_w_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_clip_x_ff <= s3_clip_x_in;
         s3_clip_y_ff <= s3_clip_y_in;
         s3_w_ff      <= s2_w_ff;
         s3_wz_ff     <= s3_wz_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: shift ndc -1..1 to 0..2, numerator = clip + w; |w| for divisor
   // ------------------------------------------------------------------
   logic signed [NUM_W-1:0] s4_num_x_in, s4_num_x_ff;
   logic signed [NUM_W-1:0] s4_num_y_in, s4_num_y_ff;
   logic [WMAG_W-1:0]       s4_wmag_in, s4_wmag_ff;
   logic                    s4_wneg_ff, s4_wz_ff;

   always_comb begin
      s4_num_x_in = NUM_W'(s3_clip_x_ff) + (NUM_W'(s3_w_ff) <<< FRAC);
      s4_num_y_in = NUM_W'(s3_clip_y_ff) + (NUM_W'(s3_w_ff) <<< FRAC);
      s4_wmag_in  = s3_w_ff[W_W-1] ? WMAG_W'(-s3_w_ff) : WMAG_W'(s3_w_ff);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_num_x_ff <= s4_num_x_in;
         s4_num_y_ff <= s4_num_y_in;
         s4_wmag_ff  <= s4_wmag_in;
         s4_wneg_ff  <= s3_w_ff[W_W-1];
         s4_wz_ff    <= s3_wz_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: numerator times window size, split in half-word products
   // ------------------------------------------------------------------
   logic [SIZE_W-1:0]      size_w, size_h;
   logic signed [HI_W-1:0] s5_hi_x_in, s5_hi_x_ff, s5_hi_y_in, s5_hi_y_ff;
   logic [LO_W-1:0]        s5_lo_x_in, s5_lo_x_ff, s5_lo_y_in, s5_lo_y_ff;
   logic [WMAG_W-1:0]      s5_wmag_ff;
   logic                   s5_wneg_ff, s5_wz_ff;

   assign size_w = view_ff[SIZE_W-1:0];
   assign size_h = view_ff[VIEW_W-1:SIZE_W];

   always_comb begin
      s5_hi_x_in = HI_W'($signed(s4_num_x_ff[NUM_W-1:HALF_W]) * $signed({1'b0, size_w}));
      s5_hi_y_in = HI_W'($signed(s4_num_y_ff[NUM_W-1:HALF_W]) * $signed({1'b0, size_h}));
      s5_lo_x_in = LO_W'(s4_num_x_ff[HALF_W-1:0] * size_w);
      s5_lo_y_in = LO_W'(s4_num_y_ff[HALF_W-1:0] * size_h);
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_hi_x_ff <= s5_hi_x_in;
         s5_hi_y_ff <= s5_hi_y_in;
         s5_lo_x_ff <= s5_lo_x_in;
         s5_lo_y_ff <= s5_lo_y_in;
         s5_wmag_ff <= s4_wmag_ff;
         s5_wneg_ff <= s4_wneg_ff;
         s5_wz_ff   <= s4_wz_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 6: recombine partial products
   // ------------------------------------------------------------------
   logic signed [PROD_W-1:0] s6_prod_x_in, s6_prod_x_ff;
   logic signed [PROD_W-1:0] s6_prod_y_in, s6_prod_y_ff;
   logic [WMAG_W-1:0]        s6_wmag_ff;
   logic                     s6_wneg_ff, s6_wz_ff;

   always_comb begin
      s6_prod_x_in = (PROD_W'(s5_hi_x_ff) <<< HALF_W)
                   + $signed({{(PROD_W-LO_W){1'b0}}, s5_lo_x_ff});
      s6_prod_y_in = (PROD_W'(s5_hi_y_ff) <<< HALF_W)
                   + $signed({{(PROD_W-LO_W){1'b0}}, s5_lo_y_ff});
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_prod_x_ff <= s6_prod_x_in;
         s6_prod_y_ff <= s6_prod_y_in;
         s6_wmag_ff   <= s5_wmag_ff;
         s6_wneg_ff   <= s5_wneg_ff;
         s6_wz_ff     <= s5_wz_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 7: sign/magnitude for the divider, divisor = |w| * 32
   // ------------------------------------------------------------------
   div_in_type div_in_in, div_in_ff;

   always_comb begin
      div_in_in.mag_x  = s6_prod_x_ff[PROD_W-1] ? NMAG_W'(-s6_prod_x_ff)
                                                : NMAG_W'(s6_prod_x_ff);
      div_in_in.neg_x  = s6_prod_x_ff[PROD_W-1] ^ s6_wneg_ff;
      div_in_in.mag_y  = s6_prod_y_ff[PROD_W-1] ? NMAG_W'(-s6_prod_y_ff)
                                                : NMAG_W'(s6_prod_y_ff);
      div_in_in.neg_y  = s6_prod_y_ff[PROD_W-1] ^ s6_wneg_ff;
      div_in_in.den    = DEN_W'(s6_wmag_ff) << DEN_SHIFT;
      div_in_in.w_zero = s6_wz_ff;
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         div_in_ff <= div_in_in;
      end
   end

   // ------------------------------------------------------------------
   // stages 8..33: range check, quotient bits, saturation
   // ------------------------------------------------------------------
   win_type win;

   vptw_divide u_divide (
      .clock  (clock),
      .en     (en[NST-1:FRONT_STAGES]),
      .div_in (div_in_ff),
      .win    (win)
   );

   assign rsp_win_x  = win.win_x;
   assign rsp_win_y  = win.win_y;
   assign rsp_w_zero = win.w_zero;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // input backpressure only when the whole pipe is full and blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&v_ff) && rsp_stall))
      else $error("request stalled with room in the pipeline");

   // an accepted request always occupies the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v_ff[0])
      else $error("accepted request lost at pipeline entry");

   // zero divisor forces zero coordinates
   a_wzero_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_w_zero) |-> ((rsp_win_x == '0) && (rsp_win_y == '0)))
      else $error("zero divisor response with nonzero coordinates");

   // a taken response with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !v_ff[NST-2]) |=> !rsp_valid)
      else $error("response repeated after being taken");

endmodule

`default_nettype wire
